### design/crt_pkg.sv
// Shared types, codes and widths of the client reference count table.
package crt_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;
    localparam int COUNT_BITS_DEF    = 16;

    localparam int ID_W      = 16;
    localparam int IN_CNT_W  = 16;
    localparam int OUT_CNT_W = 17;
    localparam int OUT_LIMIT = 65535;

    localparam int S_TDATA_W = 72;
    localparam int S_TUSER_W = 3;
    localparam int RES_W     = 55;
    localparam int M_TDATA_W = 56;

    typedef enum logic [2:0] {
        MODE_OPEN     = 3'd0,
        MODE_REOPEN   = 3'd1,
        MODE_CLOSE    = 3'd2,
        MODE_RMWRITER = 3'd3,
        MODE_KILL     = 3'd4,
        MODE_STATUS   = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_UNDER = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FETCH,
        S_EXEC,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic fetch;
        logic exec;
        logic emit;
    } crt_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } crt_stat_t;

endpackage

### design/crt_ctrl.sv
// Request sequencer of the client reference count table.
module crt_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  crt_pkg::crt_stat_t  stat,
    output crt_pkg::crt_cmd_t   cmd
);

    crt_pkg::state_t state_reg;
    crt_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= crt_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            crt_pkg::S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = crt_pkg::S_SCAN;
                end
            end
            crt_pkg::S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = crt_pkg::S_FETCH;
                end
            end
            crt_pkg::S_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = crt_pkg::S_EXEC;
            end
            crt_pkg::S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = crt_pkg::S_RESULT;
            end
            crt_pkg::S_RESULT:
            begin
                // hold the result until the output register frees up
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = crt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = crt_pkg::S_IDLE;
            end
        endcase
    end

endmodule

### design/crt_datapath.sv
// Table storage, scan, count update and result register of the client table.
module crt_datapath #(
    parameter int TABLE_ENTRIES = crt_pkg::TABLE_ENTRIES_DEF,
    parameter int COUNT_BITS    = crt_pkg::COUNT_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  crt_pkg::crt_cmd_t              cmd,
    output crt_pkg::crt_stat_t             stat,
    input  logic [crt_pkg::S_TDATA_W-1:0]  req_data,
    input  logic [crt_pkg::S_TUSER_W-1:0]  req_user,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [crt_pkg::M_TDATA_W-1:0]  out_data
);

    localparam int N   = TABLE_ENTRIES;
    localparam int CB  = COUNT_BITS;
    localparam int IW  = (N > 1) ? $clog2(N) : 1;
    localparam int CW  = $clog2(N + 1) + 1;
    localparam int XW  = (CB > crt_pkg::IN_CNT_W) ? CB : crt_pkg::IN_CNT_W;
    localparam int DW  = XW + 2;
    localparam int OW  = crt_pkg::OUT_CNT_W;
    localparam logic [XW-1:0]        CMAX_X = XW'({CB{1'b1}});
    localparam logic signed [DW-1:0] LIM_P  = DW'(crt_pkg::OUT_LIMIT);
    localparam logic signed [DW-1:0] LIM_N  = -LIM_P;

    // captured request
    crt_pkg::mode_t                 mode_reg;
    logic [crt_pkg::ID_W-1:0]       id_reg;
    logic                           wf_reg;
    logic                           xf_reg;
    logic                           cin_reg;
    logic [CB-1:0]                  rin_reg;
    logic [CB-1:0]                  win_reg;
    logic [CB-1:0]                  xin_reg;

    // table storage
    logic [N-1:0]                   valid_reg;
    logic [crt_pkg::ID_W-1:0]       mem_client [N];
    logic [CB-1:0]                  mem_refs   [N];
    logic [CB-1:0]                  mem_writers[N];
    logic [CB-1:0]                  mem_execs  [N];
    logic                           mem_cached [N];

    logic [crt_pkg::ID_W-1:0]       rd_client_reg;
    logic [CB-1:0]                  rd_refs_reg;
    logic [CB-1:0]                  rd_writers_reg;
    logic [CB-1:0]                  rd_execs_reg;
    logic                           rd_cached_reg;

    // scan state
    logic [CW-1:0]                  scan_cnt_reg;
    logic                           chk_live_reg;
    logic [IW-1:0]                  chk_idx_reg;
    logic                           hit_reg;
    logic [IW-1:0]                  hit_idx_reg;
    logic                           free_reg;
    logic [IW-1:0]                  free_idx_reg;

    logic [crt_pkg::RES_W-1:0]      res_reg;
    logic                           out_valid_reg;
    logic [crt_pkg::M_TDATA_W-1:0]  out_data_reg;

    logic                           issue;
    logic                           rd_en;
    logic [IW-1:0]                  rd_addr;
    logic [IW-1:0]                  target;
    logic                           chk_match;
    logic                           chk_free;

    function automatic logic [CB-1:0] clamp_in(input logic [crt_pkg::IN_CNT_W-1:0] v);
        logic [XW-1:0] ext;
        ext = XW'(v);
        return (ext > CMAX_X) ? CB'(CMAX_X) : CB'(ext);
    endfunction

    function automatic logic [CB-1:0] sat_add(input logic [CB-1:0] a, input logic [CB-1:0] b);
        logic [CB:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CB] ? {CB{1'b1}} : s[CB-1:0];
    endfunction

    // returns {underflow, value}
    function automatic logic [CB:0] dec_clamp(input logic [CB-1:0] a);
        return (a == '0) ? {1'b1, {CB{1'b0}}} : {1'b0, a - CB'(1)};
    endfunction

    function automatic logic signed [DW-1:0] widen(input logic [CB-1:0] a);
        return $signed({{(DW - CB){1'b0}}, a});
    endfunction

    function automatic logic [OW-1:0] enc_out(input logic signed [DW-1:0] v);
        logic signed [DW-1:0] c;
        c = v;
        if (c > LIM_P)
        begin
            c = LIM_P;
        end
        if (c < LIM_N)
        begin
            c = LIM_N;
        end
        return c[OW-1:0];
    endfunction

    assign issue   = cmd.scan && (scan_cnt_reg < CW'(N));
    assign target  = hit_reg ? hit_idx_reg : free_idx_reg;
    assign rd_en   = issue || cmd.fetch;
    assign rd_addr = cmd.fetch ? target : scan_cnt_reg[IW-1:0];

    assign chk_match = chk_live_reg && valid_reg[chk_idx_reg] && (rd_client_reg == id_reg);
    assign chk_free  = chk_live_reg && !valid_reg[chk_idx_reg];

    assign stat.scan_done = chk_live_reg && (chk_idx_reg == IW'(N - 1));
    assign stat.out_free  = !out_valid_reg || out_ready;

    // capture the request and run the scan
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= crt_pkg::mode_t'(req_user[2:0]);
            id_reg   <= req_data[15:0];
            wf_reg   <= req_data[16];
            xf_reg   <= req_data[17];
            cin_reg  <= req_data[18];
            rin_reg  <= clamp_in(req_data[34:19]);
            win_reg  <= clamp_in(req_data[50:35]);
            xin_reg  <= clamp_in(req_data[66:51]);
        end
        chk_idx_reg <= scan_cnt_reg[IW-1:0];
        if (chk_match && !hit_reg)
        begin
            hit_idx_reg <= chk_idx_reg;
        end
        if (chk_free && !free_reg)
        begin
            free_idx_reg <= chk_idx_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_cnt_reg <= '0;
            chk_live_reg <= 1'b0;
            hit_reg      <= 1'b0;
            free_reg     <= 1'b0;
        end
        else
        begin
            chk_live_reg <= issue;
            if (cmd.load)
            begin
                scan_cnt_reg <= '0;
                hit_reg      <= 1'b0;
                free_reg     <= 1'b0;
            end
            else
            begin
                if (issue)
                begin
                    scan_cnt_reg <= scan_cnt_reg + CW'(1);
                end
                if (chk_match)
                begin
                    hit_reg <= 1'b1;
                end
                if (chk_free)
                begin
                    free_reg <= 1'b1;
                end
            end
        end
    end

    // update of the selected entry
    logic                 wr_en;
    logic                 set_valid;
    logic                 clr_valid;
    logic [CB-1:0]        base_refs;
    logic [CB-1:0]        base_writers;
    logic [CB-1:0]        base_execs;
    logic                 base_cached;
    logic [CB-1:0]        new_refs;
    logic [CB-1:0]        new_writers;
    logic [CB-1:0]        new_execs;
    logic                 new_cached;
    logic [CB:0]          dr;
    logic [CB:0]          dw;
    logic [CB:0]          dx;
    logic                 under;
    logic                 cout;
    logic signed [DW-1:0] r_val;
    logic signed [DW-1:0] w_val;
    logic signed [DW-1:0] x_val;
    crt_pkg::status_t     st;

    always_comb
    begin
        base_refs    = hit_reg ? rd_refs_reg    : '0;
        base_writers = hit_reg ? rd_writers_reg : '0;
        base_execs   = hit_reg ? rd_execs_reg   : '0;
        base_cached  = hit_reg ? rd_cached_reg  : 1'b0;
        new_refs     = base_refs;
        new_writers  = base_writers;
        new_execs    = base_execs;
        new_cached   = base_cached;
        dr           = dec_clamp(base_refs);
        dw           = dec_clamp(base_writers);
        dx           = dec_clamp(base_execs);
        wr_en        = 1'b0;
        set_valid    = 1'b0;
        clr_valid    = 1'b0;
        under        = 1'b0;
        cout         = cin_reg;
        r_val        = '0;
        w_val        = '0;
        x_val        = '0;
        st           = crt_pkg::ST_OK;
        unique case (mode_reg) inside
            crt_pkg::MODE_OPEN, crt_pkg::MODE_REOPEN:
            begin
                if (!hit_reg && !free_reg)
                begin
                    st = crt_pkg::ST_FULL;
                end
                else
                begin
                    wr_en     = 1'b1;
                    set_valid = !hit_reg;
                    if (mode_reg == crt_pkg::MODE_OPEN)
                    begin
                        new_cached = cin_reg;
                        new_refs   = sat_add(base_refs, CB'(1));
                        if (wf_reg)
                        begin
                            new_writers = sat_add(base_writers, CB'(1));
                        end
                        if (xf_reg)
                        begin
                            new_execs = sat_add(base_execs, CB'(1));
                        end
                    end
                    else
                    begin
                        new_refs    = sat_add(base_refs, rin_reg);
                        new_writers = sat_add(base_writers, win_reg);
                        new_execs   = sat_add(base_execs, xin_reg);
                    end
                end
            end
            crt_pkg::MODE_CLOSE:
            begin
                if (hit_reg)
                begin
                    wr_en    = 1'b1;
                    new_refs = dr[CB-1:0];
                    under    = dr[CB];
                    if (wf_reg)
                    begin
                        new_writers = dw[CB-1:0];
                        under       = under | dw[CB];
                    end
                    if (xf_reg)
                    begin
                        new_execs = dx[CB-1:0];
                        under     = under | dx[CB];
                    end
                    cout = base_cached;
                    // free once the refs count reaches zero, unless both sides mark it cached
                    if ((!cin_reg || !base_cached) && (dr[CB-1:0] == '0))
                    begin
                        clr_valid = 1'b1;
                    end
                end
            end
            crt_pkg::MODE_RMWRITER:
            begin
                if (hit_reg)
                begin
                    wr_en       = 1'b1;
                    new_writers = dw[CB-1:0];
                    under       = dw[CB];
                end
            end
            crt_pkg::MODE_KILL:
            begin
                if (hit_reg)
                begin
                    r_val     = widen(base_refs);
                    w_val     = widen(base_writers);
                    x_val     = widen(base_execs);
                    clr_valid = 1'b1;
                end
            end
            crt_pkg::MODE_STATUS:
            begin
                r_val = widen(rin_reg) - widen(base_refs);
                w_val = widen(win_reg) - widen(base_writers);
                x_val = widen(xin_reg) - widen(base_execs);
            end
            default:
            begin
                st = crt_pkg::ST_OK;
            end
        endcase
        if (under)
        begin
            st = crt_pkg::ST_UNDER;
        end
    end

    // table memory, written on update and read through a registered port, plus the result and output data registers
    always_ff @(posedge clk)
    begin
        if (cmd.exec && wr_en)
        begin
            mem_client[target]  <= id_reg;
            mem_refs[target]    <= new_refs;
            mem_writers[target] <= new_writers;
            mem_execs[target]   <= new_execs;
            mem_cached[target]  <= new_cached;
        end
        if (rd_en)
        begin
            rd_client_reg  <= mem_client[rd_addr];
            rd_refs_reg    <= mem_refs[rd_addr];
            rd_writers_reg <= mem_writers[rd_addr];
            rd_execs_reg   <= mem_execs[rd_addr];
            rd_cached_reg  <= mem_cached[rd_addr];
        end
        if (cmd.exec)
        begin
            res_reg <= {st, enc_out(x_val), enc_out(w_val), enc_out(r_val), cout, hit_reg};
        end
        if (cmd.emit)
        begin
            out_data_reg <= {1'b0, res_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.exec && set_valid)
            begin
                valid_reg[target] <= 1'b1;
            end
            if (cmd.exec && clr_valid)
            begin
                valid_reg[target] <= 1'b0;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

### design/client_refcount_table.sv
// Top level of the client reference count table.
//
//   channel   dir  handshake           payload
//   request   in   s_tvalid/s_tready   s_tuser: mode; s_tdata: id, flags, counts
//   result    out  m_tvalid/m_tready   m_tdata: found, cached, counts, status
//
// After acceptance, the scan reads one entry per cycle through the single
// registered memory port and compares it in the cycle after; the fetch state
// then reads the matched or free entry, the update state writes it back where
// the mode changes it and loads the result register, and the result state moves
// it into the output register once that is free.
// The next request is taken only once the block is back in idle.
// Reset clears the valid bits, the scan flags and the output valid; entry contents need no clearing.
// A new request is taken while the previous result still waits in the
// output register; a stalled result holds the block before its next load.
module client_refcount_table #(
    parameter int TABLE_ENTRIES = crt_pkg::TABLE_ENTRIES_DEF,
    parameter int COUNT_BITS    = crt_pkg::COUNT_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [15:0] client_id, [16] write_flag, [17] exec_flag, [18] cached_in,
    // [34:19] ref_in, [50:35] write_in, [66:51] exec_in, [71:67] zero
    input  logic [crt_pkg::S_TDATA_W-1:0]  s_tdata,
    // [2:0] mode
    input  logic [crt_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [0] found, [1] cached_out, [18:2] ref_out, [35:19] write_out,
    // [52:36] exec_out, [54:53] status, [55] zero
    output logic [crt_pkg::M_TDATA_W-1:0]  m_tdata
);

    crt_pkg::crt_cmd_t  cmd;
    crt_pkg::crt_stat_t stat;

    // sequence each request: scan, fetch, update, hand off
    crt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // table, counters and the output register
    crt_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .COUNT_BITS    (COUNT_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .req_data  (s_tdata),
        .req_user  (s_tuser),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule

### design/crt_checker.sv
// Port-level checks of the client reference count table and their binding.
module crt_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [crt_pkg::M_TDATA_W-1:0]  m_tdata
);

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

    // one request at a time
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request taken while busy");

    // a result is loaded as the block returns to idle
    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> s_tready)
        else $error("result loaded while busy");

    // a full table is only reported on a miss
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[54:53] == crt_pkg::ST_FULL)) |-> !m_tdata[0])
        else $error("table full reported on a hit");

    // underflow needs an existing entry
    a_under: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[54:53] == crt_pkg::ST_UNDER)) |-> m_tdata[0])
        else $error("underflow reported on a miss");

endmodule

bind client_refcount_table crt_checker u_crt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### bench/client_refcount_table_test.sv
// Self-checking testbench for the client reference count table.
module client_refcount_table_test;

    import crt_pkg::*;

    localparam int TABLE_SLOTS    = TABLE_ENTRIES_DEF;
    localparam int RANDOM_ITEMS   = 900;
    localparam int POOL_IDS       = 24;
    // Cycles allowed with no request or result moving. One request needs the
    // scan plus fetch and write-back; add the longest sender gap and a long
    // result stall, then leave a wide margin.
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = TABLE_SLOTS + 12;

    // One request as the block sees it.
    typedef struct packed {
        mode_t       mode;
        logic [15:0] client_id;
        logic        write_flag;
        logic        exec_flag;
        logic        cached_in;
        logic [15:0] ref_in;
        logic [15:0] write_in;
        logic [15:0] exec_in;
    } request_t;

    // One result: lookup outcome, cached flag, signed counts and status.
    typedef struct packed {
        logic                        found;
        logic                        cached_out;
        logic signed [OUT_CNT_W-1:0] ref_out;
        logic signed [OUT_CNT_W-1:0] write_out;
        logic signed [OUT_CNT_W-1:0] exec_out;
        status_t                     status;
    } usage_result_t;

    // Directed row: a request, and a result typed in where it is obvious.
    typedef struct packed {
        request_t      req;
        logic          typed;
        usage_result_t want;
    } directed_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [S_TUSER_W-1:0] s_tuser;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    // Shadow copy of the client table.
    bit   [TABLE_SLOTS-1:0] slot_valid;
    logic [15:0]            slot_client  [TABLE_SLOTS];
    logic [15:0]            slot_refs    [TABLE_SLOTS];
    logic [15:0]            slot_writers [TABLE_SLOTS];
    logic [15:0]            slot_execs   [TABLE_SLOTS];
    logic                   slot_cached  [TABLE_SLOTS];

    usage_result_t pending_results[$];
    logic [15:0]   id_pool [POOL_IDS];
    bit            steady_run = 1'b0;
    int            fault_count;
    int            stall_cycles;
    int            mode_seen [6];
    int            hit_results;
    int            full_results;
    int            under_results;

    // Walk these first: misses on every mode, saturation, cached keep,
    // underflow clamping and record release.
    directed_row_t plan [23] = '{
        // status on a miss passes the given counts through
        '{'{MODE_STATUS, 16'h0005, 1'b0, 1'b0, 1'b1, 16'hFFFF, 16'h0000, 16'h1234}, 1'b1,
          '{1'b0, 1'b1, 17'sd65535, 17'sd0, 17'sh01234, ST_OK}},
        '{'{MODE_CLOSE, 16'hFFFF, 1'b1, 1'b1, 1'b1, 16'h0000, 16'h0000, 16'h0000}, 1'b1,
          '{1'b0, 1'b1, 17'sd0, 17'sd0, 17'sd0, ST_OK}},
        '{'{MODE_RMWRITER, 16'hFFFF, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000}, 1'b1,
          '{1'b0, 1'b0, 17'sd0, 17'sd0, 17'sd0, ST_OK}},
        '{'{MODE_KILL, 16'h0000, 1'b0, 1'b0, 1'b1, 16'h0000, 16'h0000, 16'h0000}, 1'b1,
          '{1'b0, 1'b1, 17'sd0, 17'sd0, 17'sd0, ST_OK}},
        '{'{MODE_OPEN, 16'hFFFF, 1'b1, 1'b1, 1'b1, 16'h0000, 16'h0000, 16'h0000}, 1'b1,
          '{1'b0, 1'b1, 17'sd0, 17'sd0, 17'sd0, ST_OK}},
        '{'{MODE_STATUS, 16'hFFFF, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000}, 1'b1,
          '{1'b1, 1'b0, -17'sd1, -17'sd1, -17'sd1, ST_OK}},
        // saturate every count at the top
        '{'{MODE_REOPEN, 16'hFFFF, 1'b0, 1'b0, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1,
          '{1'b1, 1'b0, 17'sd0, 17'sd0, 17'sd0, ST_OK}},
        '{'{MODE_STATUS, 16'hFFFF, 1'b0, 1'b0, 1'b1, 16'h0000, 16'h0000, 16'h0000}, 1'b1,
          '{1'b1, 1'b1, -17'sd65535, -17'sd65535, -17'sd65535, ST_OK}},
        '{'{MODE_KILL, 16'hFFFF, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000}, 1'b1,
          '{1'b1, 1'b0, 17'sd65535, 17'sd65535, 17'sd65535, ST_OK}},
        '{'{MODE_STATUS, 16'hFFFF, 1'b0, 1'b0, 1'b0, 16'h0007, 16'h0000, 16'h0000}, 1'b1,
          '{1'b0, 1'b0, 17'sd7, 17'sd0, 17'sd0, ST_OK}},
        // close with writer underflow frees the record
        '{'{MODE_OPEN, 16'h0000, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000}, 1'b1,
          '{1'b0, 1'b0, 17'sd0, 17'sd0, 17'sd0, ST_OK}},
        '{'{MODE_CLOSE, 16'h0000, 1'b1, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000}, 1'b1,
          '{1'b1, 1'b0, 17'sd0, 17'sd0, 17'sd0, ST_UNDER}},
        // both sides cached: the record outlives its last reference
        '{'{MODE_OPEN, 16'h8001, 1'b1, 1'b1, 1'b1, 16'h0000, 16'h0000, 16'h0000}, 1'b0, '0},
        '{'{MODE_CLOSE, 16'h8001, 1'b1, 1'b1, 1'b1, 16'h0000, 16'h0000, 16'h0000}, 1'b1,
          '{1'b1, 1'b1, 17'sd0, 17'sd0, 17'sd0, ST_OK}},
        '{'{MODE_STATUS, 16'h8001, 1'b0, 1'b0, 1'b0, 16'h0002, 16'h0003, 16'h0004}, 1'b0, '0},
        '{'{MODE_RMWRITER, 16'h8001, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000}, 1'b1,
          '{1'b1, 1'b0, 17'sd0, 17'sd0, 17'sd0, ST_UNDER}},
        '{'{MODE_CLOSE, 16'h8001, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000}, 1'b1,
          '{1'b1, 1'b1, 17'sd0, 17'sd0, 17'sd0, ST_UNDER}},
        '{'{MODE_STATUS, 16'h8001, 1'b0, 1'b0, 1'b0, 16'h8000, 16'h7FFF, 16'h0001}, 1'b1,
          '{1'b0, 1'b0, 17'sd32768, 17'sd32767, 17'sd1, ST_OK}},
        // reopen inserts a fresh record, then walk it through open, close, kill and remove writer
        '{'{MODE_REOPEN, 16'h4242, 1'b0, 1'b0, 1'b1, 16'h0003, 16'h0001, 16'h0002}, 1'b0, '0},
        '{'{MODE_OPEN, 16'h4242, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000}, 1'b0, '0},
        '{'{MODE_CLOSE, 16'h4242, 1'b1, 1'b1, 1'b1, 16'h0000, 16'h0000, 16'h0000}, 1'b0, '0},
        '{'{MODE_KILL, 16'h4242, 1'b1, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0, '0},
        '{'{MODE_RMWRITER, 16'h4242, 1'b1, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0, '0}
    };

    client_refcount_table uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Add with saturation at the count's top value.
    function automatic logic [15:0] raise_count(input logic [15:0] count,
                                                input logic [15:0] amount);
        logic [16:0] sum;
        sum = {1'b0, count} + {1'b0, amount};
        return sum[16] ? 16'hFFFF : sum[15:0];
    endfunction

    // Decrement, holding at zero and flagging the underflow.
    function automatic logic [15:0] lower_count(input logic [15:0] count, inout bit under);
        if (count == 16'd0)
        begin
            under = 1'b1;
            return 16'd0;
        end
        return count - 16'd1;
    endfunction

    // Apply one request to the shadow table and return the result it yields.
    function automatic usage_result_t apply_request(input request_t rq);
        usage_result_t res;
        int            slot;
        int            i;
        bit            hit;
        bit            under;
        slot  = -1;
        under = 1'b0;
        for (i = 0; i < TABLE_SLOTS; i++)
            if (slot < 0 && slot_valid[i] && slot_client[i] == rq.client_id)
                slot = i;
        hit            = (slot >= 0);
        res.found      = hit;
        res.cached_out = rq.cached_in;
        res.ref_out    = '0;
        res.write_out  = '0;
        res.exec_out   = '0;
        res.status     = ST_OK;
        case (rq.mode)
            MODE_OPEN, MODE_REOPEN:
            begin
                // miss: claim the lowest free slot with cleared counts
                if (!hit)
                    for (i = 0; i < TABLE_SLOTS; i++)
                        if (slot < 0 && !slot_valid[i])
                        begin
                            slot            = i;
                            slot_valid[i]   = 1'b1;
                            slot_client[i]  = rq.client_id;
                            slot_refs[i]    = '0;
                            slot_writers[i] = '0;
                            slot_execs[i]   = '0;
                            slot_cached[i]  = 1'b0;
                        end
                if (slot < 0)
                    res.status = ST_FULL;
                else if (rq.mode == MODE_OPEN)
                begin
                    slot_cached[slot] = rq.cached_in;
                    slot_refs[slot]   = raise_count(slot_refs[slot], 16'd1);
                    if (rq.write_flag)
                        slot_writers[slot] = raise_count(slot_writers[slot], 16'd1);
                    if (rq.exec_flag)
                        slot_execs[slot] = raise_count(slot_execs[slot], 16'd1);
                end
                else
                begin
                    slot_refs[slot]    = raise_count(slot_refs[slot], rq.ref_in);
                    slot_writers[slot] = raise_count(slot_writers[slot], rq.write_in);
                    slot_execs[slot]   = raise_count(slot_execs[slot], rq.exec_in);
                end
            end
            MODE_CLOSE:
                if (hit)
                begin
                    slot_refs[slot] = lower_count(slot_refs[slot], under);
                    if (rq.write_flag)
                        slot_writers[slot] = lower_count(slot_writers[slot], under);
                    if (rq.exec_flag)
                        slot_execs[slot] = lower_count(slot_execs[slot], under);
                    res.cached_out = slot_cached[slot];
                    // once refs reach zero, keep the record only while both sides call it cached
                    if ((!rq.cached_in || !slot_cached[slot]) && slot_refs[slot] == 16'd0)
                        slot_valid[slot] = 1'b0;
                end
            MODE_RMWRITER:
                if (hit)
                    slot_writers[slot] = lower_count(slot_writers[slot], under);
            MODE_KILL:
                if (hit)
                begin
                    res.ref_out      = {1'b0, slot_refs[slot]};
                    res.write_out    = {1'b0, slot_writers[slot]};
                    res.exec_out     = {1'b0, slot_execs[slot]};
                    slot_valid[slot] = 1'b0;
                end
            MODE_STATUS:
            begin
                res.ref_out   = {1'b0, rq.ref_in};
                res.write_out = {1'b0, rq.write_in};
                res.exec_out  = {1'b0, rq.exec_in};
                if (hit)
                begin
                    res.ref_out   = res.ref_out - $signed({1'b0, slot_refs[slot]});
                    res.write_out = res.write_out - $signed({1'b0, slot_writers[slot]});
                    res.exec_out  = res.exec_out - $signed({1'b0, slot_execs[slot]});
                end
            end
            default: ;
        endcase
        if (under)
            res.status = ST_UNDER;
        return res;
    endfunction

    // Draw a request: mostly ids from a small pool so records get reused,
    // collide and fill the table; an occasional id from anywhere.
    function automatic request_t random_request(input int unsigned pool_size);
        request_t    rq;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 30)
            rq.mode = MODE_OPEN;
        else if (pick < 40)
            rq.mode = MODE_REOPEN;
        else if (pick < 65)
            rq.mode = MODE_CLOSE;
        else if (pick < 75)
            rq.mode = MODE_RMWRITER;
        else if (pick < 83)
            rq.mode = MODE_KILL;
        else
            rq.mode = MODE_STATUS;
        if ($urandom_range(15) == 0)
            rq.client_id = 16'($urandom);
        else
            rq.client_id = id_pool[$urandom_range(pool_size - 1)];
        rq.write_flag = 1'($urandom_range(1));
        rq.exec_flag  = 1'($urandom_range(1));
        rq.cached_in  = 1'($urandom_range(1));
        rq.ref_in     = 16'($urandom);
        rq.write_in   = 16'($urandom);
        rq.exec_in    = 16'($urandom);
        // keep most reopen amounts small so closes can still free records
        if (rq.mode == MODE_REOPEN && $urandom_range(9) != 0)
        begin
            rq.ref_in   = 16'($urandom_range(3));
            rq.write_in = 16'($urandom_range(3));
            rq.exec_in  = 16'($urandom_range(3));
        end
        return rq;
    endfunction

    // Offer one request, hold it until taken, then record what it should yield.
    // A row with a typed-in result queues that instead of the prediction.
    task automatic send_request(input request_t rq, input logic typed,
                                input usage_result_t want);
        usage_result_t predicted;
        if (!steady_run && $urandom_range(99) < 34)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= rq.mode;
        s_tdata  <= {5'b0, rq.exec_in, rq.write_in, rq.ref_in,
                     rq.cached_in, rq.exec_flag, rq.write_flag, rq.client_id};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted = apply_request(rq);
        pending_results.push_back(typed ? want : predicted);
        mode_seen[rq.mode]++;
    endtask

    task automatic report_fault(input string what, input usage_result_t want,
                                input usage_result_t got);
        fault_count++;
        if (fault_count <= 10)
            $display("%s: expected found=%0b cached=%0b refs=%0d writers=%0d execs=%0d st=%0d,",
                     what, want.found, want.cached_out, want.ref_out, want.write_out,
                     want.exec_out, want.status,
                     " got found=%0b cached=%0b refs=%0d writers=%0d execs=%0d st=%0d",
                     got.found, got.cached_out, got.ref_out, got.write_out,
                     got.exec_out, got.status);
    endtask

    // Result side: stall at random, except through the steady stretch.
    always @(posedge clk)
        m_tready <= steady_run || ($urandom_range(99) >= 34);

    // Compare each result taken at this edge with the oldest expectation.
    always @(posedge clk)
    begin
        usage_result_t got;
        usage_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.found      = m_tdata[0];
            got.cached_out = m_tdata[1];
            got.ref_out    = m_tdata[18:2];
            got.write_out  = m_tdata[35:19];
            got.exec_out   = m_tdata[52:36];
            got.status     = status_t'(m_tdata[54:53]);
            hit_results   += got.found;
            full_results  += (got.status == ST_FULL);
            under_results += (got.status == ST_UNDER);
            if (pending_results.size() == 0)
                report_fault("unexpected result", '0, got);
            else
            begin
                want = pending_results.pop_front();
                if (got.found !== want.found || got.cached_out !== want.cached_out
                    || got.ref_out !== want.ref_out || got.write_out !== want.write_out
                    || got.exec_out !== want.exec_out || got.status !== want.status)
                    report_fault("result mismatch", want, got);
            end
        end
    end

    // Abort when neither side moves for too long.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles == WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        int unsigned pool_size;
        int          n;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        slot_valid   = '0;
        pool_size    = POOL_IDS;
        foreach (id_pool[i])
            id_pool[i] = 16'($urandom);
        // pin the id extremes into the pool
        id_pool[0] = 16'h0000;
        id_pool[1] = 16'hFFFF;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
            send_request(plan[i].req, plan[i].typed, plan[i].want);

        // Random traffic; vary the pool size per block so the table swings
        // between sparse use and table-full pressure.
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 100 == 0)
                pool_size = $urandom_range(4, POOL_IDS);
            steady_run <= (n >= 400 && n < 550);
            send_request(random_request(pool_size), 1'b0, '0);
        end
        s_tvalid   <= 1'b0;
        steady_run <= 1'b0;

        // Drain; a missing result trips the watchdog.
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("requests: open %0d, reopen %0d, close %0d, remove writer %0d,",
                 mode_seen[MODE_OPEN], mode_seen[MODE_REOPEN], mode_seen[MODE_CLOSE],
                 mode_seen[MODE_RMWRITER],
                 " kill %0d, status %0d", mode_seen[MODE_KILL], mode_seen[MODE_STATUS]);
        $display("results: %0d hits, %0d table full, %0d underflows",
                 hit_results, full_results, under_results);
        if (fault_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
